// ===== hw/rtl/session_table_lru_aging_core_assert.svh =====
// Assertion macros for the session table core checker.
// Expects signals named clock and reset in the scope of use.
`ifndef SESSION_TABLE_LRU_AGING_CORE_ASSERT_SVH
`define SESSION_TABLE_LRU_AGING_CORE_ASSERT_SVH

// same-cycle implication
`define STLA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stla_pkg.sv =====
// Shared constants and types for the session table core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package stla_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int ID_W          = 32;
   localparam int TIME_W        = 32;
   localparam int SLOT_OUT_W    = 3;
   localparam int COUNT_OUT_W   = 4;
   localparam int REQ_DATA_W    = ID_W + TIME_W;
   localparam int RSP_DATA_W    = SLOT_OUT_W + 1 + ID_W + COUNT_OUT_W;

   localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RESET = 32'd600;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_EXPIRE = 1'b1;

   typedef struct packed {
      logic match;
      logic older;
      logic expired;
   } cmp_res_type;

endpackage

// ===== hw/rtl/stla_store.sv =====
// Slot storage: node id and last-activity memories with per-entry valid bits.
// Depends on stla_pkg. Unwritten entries read as zero.
`timescale 1ns / 1ps

module stla_store #(
   parameter int SLOTS = stla_pkg::SLOTS_DEFAULT,
   parameter int IDX_W = $clog2(SLOTS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [stla_pkg::ID_W-1:0]   rd_node,
   output logic [stla_pkg::TIME_W-1:0] rd_time,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic                        wr_node_en,
   input  logic [stla_pkg::ID_W-1:0]   wr_node,
   input  logic                        wr_time_en,
   input  logic [stla_pkg::TIME_W-1:0] wr_time
);

   logic [stla_pkg::ID_W-1:0]   node_mem [SLOTS];
   logic [stla_pkg::TIME_W-1:0] time_mem [SLOTS];
   logic [SLOTS-1:0]            node_vld_ff;
   logic [SLOTS-1:0]            time_vld_ff;
   logic [stla_pkg::ID_W-1:0]   node_rd_ff;
   logic [stla_pkg::TIME_W-1:0] time_rd_ff;
   logic                        node_rd_vld_ff;
   logic                        time_rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_node_en) begin
         node_mem[wr_addr] <= wr_node;
      end
      if (wr_time_en) begin
         time_mem[wr_addr] <= wr_time;
      end
      node_rd_ff <= node_mem[rd_addr];
      time_rd_ff <= time_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_vld_ff    <= '0;
         time_vld_ff    <= '0;
         node_rd_vld_ff <= 1'b0;
         time_rd_vld_ff <= 1'b0;
      end else begin
         if (wr_node_en) begin
            node_vld_ff[wr_addr] <= 1'b1;
         end
         if (wr_time_en) begin
            time_vld_ff[wr_addr] <= 1'b1;
         end
         node_rd_vld_ff <= node_vld_ff[rd_addr];
         time_rd_vld_ff <= time_vld_ff[rd_addr];
      end
   end

   assign rd_node = node_rd_vld_ff ? node_rd_ff : '0;
   assign rd_time = time_rd_vld_ff ? time_rd_ff : '0;

endmodule

// ===== hw/rtl/stla_cmp.sv =====
// Shared compare unit: id match, age order and idle test for one slot.
// Depends on stla_pkg for widths and the result struct.
`timescale 1ns / 1ps

module stla_cmp (
   input  logic                        first,
   input  logic [stla_pkg::ID_W-1:0]   key,
   input  logic [stla_pkg::ID_W-1:0]   node,
   input  logic [stla_pkg::TIME_W-1:0] slot_time,
   input  logic [stla_pkg::TIME_W-1:0] best_time,
   input  logic [stla_pkg::TIME_W-1:0] now,
   input  logic [stla_pkg::TIME_W-1:0] timeout,
   output stla_pkg::cmp_res_type       res
);

   logic [stla_pkg::TIME_W-1:0] idle;

   assign idle        = now - slot_time;
   assign res.match   = (node == key);
   assign res.older   = first || (slot_time < best_time);
   assign res.expired = (node != '0) && (idle > timeout);

endmodule

// ===== hw/rtl/session_table_lru_aging_core.sv =====
// Session table core: LRU slot assignment and idle-session expiry.
// Depends on stla_pkg, stla_store and stla_cmp.
//
// req channel carries one item: tuser = op (0 access, 1 expire), tdata = node_id
// and now. rsp channel returns exactly one item per request with slot, hit,
// evicted_node and expired_count. csr_we/csr_wdata load idle_timeout.
// Each request scans all SLOTS entries one per cycle through a single compare
// unit, reading both memories at one address per cycle. The result is
// registered on leaving ST_DONE and req_tready rises at the same edge, so
// the next item is accepted only after the last one is finished.
// req_tready is high only while no request is in progress. A finished result
// waits in the output register; the next request can be accepted and scanned
// meanwhile and holds only its final update until the register frees up.
// Reset clears all slots to id 0 and time 0 at once through valid bits,
// sets idle_timeout to 600 and drops rsp_tvalid.
`timescale 1ns / 1ps

module session_table_lru_aging_core #(
   parameter int SLOTS = stla_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [stla_pkg::REQ_DATA_W-1:0]   req_tdata,  // node_id, now
   input  logic                              req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [stla_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // slot, hit, evicted_node, expired_count
   input  logic                              csr_we,
   input  logic [stla_pkg::TIME_W-1:0]       csr_wdata
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int SCAN_W = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic                            op_ff, op_in;
   logic [stla_pkg::ID_W-1:0]       key_ff, key_in;
   logic [stla_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [SCAN_W-1:0]               idx_ff, idx_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                rd_idx_ff, rd_idx_in;
   logic                            found_ff, found_in;
   logic [IDX_W-1:0]                hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]                best_idx_ff, best_idx_in;
   logic [stla_pkg::TIME_W-1:0]     best_time_ff, best_time_in;
   logic [stla_pkg::ID_W-1:0]       best_node_ff, best_node_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [stla_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [stla_pkg::TIME_W-1:0]     timeout_ff;

   logic [stla_pkg::ID_W-1:0]       rd_node;
   logic [stla_pkg::TIME_W-1:0]     rd_time;
   logic [IDX_W-1:0]                wr_addr;
   logic                            wr_node_en;
   logic [stla_pkg::ID_W-1:0]       wr_node;
   logic                            wr_time_en;
   stla_pkg::cmp_res_type           cmp_res;
   logic [IDX_W-1:0]                use_idx;
   logic [IDX_W+stla_pkg::SLOT_OUT_W-1:0]  slot_ext;
   logic [CNT_W+stla_pkg::COUNT_OUT_W-1:0] cnt_ext;

   stla_store #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (idx_ff[IDX_W-1:0]),
      .rd_node    (rd_node),
      .rd_time    (rd_time),
      .wr_addr    (wr_addr),
      .wr_node_en (wr_node_en),
      .wr_node    (wr_node),
      .wr_time_en (wr_time_en),
      .wr_time    (now_ff)
   );

   stla_cmp u_cmp (
      .first     (rd_idx_ff == '0),
      .key       (key_ff),
      .node      (rd_node),
      .slot_time (rd_time),
      .best_time (best_time_ff),
      .now       (now_ff),
      .timeout   (timeout_ff),
      .res       (cmp_res)
   );

   assign use_idx  = found_ff ? hit_idx_ff : best_idx_ff;
   assign slot_ext = {{stla_pkg::SLOT_OUT_W{1'b0}}, use_idx};
   assign cnt_ext  = {{stla_pkg::COUNT_OUT_W{1'b0}}, cnt_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      best_node_in = best_node_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_addr      = rd_idx_ff;
      wr_node_en   = 1'b0;
      wr_node      = '0;
      wr_time_en   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               key_in    = req_tdata[stla_pkg::ID_W-1:0];
               now_in    = req_tdata[stla_pkg::REQ_DATA_W-1:stla_pkg::ID_W];
               idx_in    = '0;
               rd_vld_in = 1'b0;
               found_in  = 1'b0;
               cnt_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff != SCAN_END) begin
               idx_in    = idx_ff + SCAN_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
            end else begin
               rd_vld_in = 1'b0;
            end
            if (rd_vld_ff) begin
               if (!found_ff && cmp_res.match) begin
                  found_in   = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (cmp_res.older) begin
                  best_idx_in  = rd_idx_ff;
                  best_time_in = rd_time;
                  best_node_in = rd_node;
               end
               if (op_ff == stla_pkg::OP_EXPIRE && cmp_res.expired) begin
                  wr_node_en = 1'b1;
                  cnt_in     = cnt_ff + CNT_W'(1);
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == stla_pkg::OP_EXPIRE) begin
                  rsp_data_in = {cnt_ext[stla_pkg::COUNT_OUT_W-1:0],
                                 {stla_pkg::ID_W{1'b0}}, 1'b0,
                                 {stla_pkg::SLOT_OUT_W{1'b0}}};
               end else begin
                  wr_addr     = use_idx;
                  wr_time_en  = 1'b1;
                  wr_node_en  = !found_ff;
                  wr_node     = key_ff;
                  rsp_data_in = {{stla_pkg::COUNT_OUT_W{1'b0}},
                                 found_ff ? {stla_pkg::ID_W{1'b0}} : best_node_ff,
                                 found_ff, slot_ext[stla_pkg::SLOT_OUT_W-1:0]};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= stla_pkg::IDLE_TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      best_node_ff <= best_node_in;
      cnt_ff       <= cnt_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/stla_checker.sv =====
// Port-level checker for the session table core, bound to the top level.
// Depends on stla_pkg and session_table_lru_aging_core_assert.svh.
`timescale 1ns / 1ps
`include "session_table_lru_aging_core_assert.svh"

module stla_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [stla_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   `STLA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")
   `STLA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "req accepted while scan in progress")
   `STLA_ASSERT_IMPL(a_hit_clean, rsp_tvalid && rsp_tdata[3], rsp_tdata[39:4] == 36'd0, "hit item carries eviction or count")
   `STLA_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_tvalid && req_tready, "item pending right after reset")

endmodule

bind session_table_lru_aging_core stla_checker u_stla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_session_table_lru_aging_core.sv =====
// Self-checking bench for session_table_lru_aging_core: directed and random access/expire
// items are scored against a built-in predictor of the slot table.
// Depends on stla_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_session_table_lru_aging_core;

   localparam int SLOTS            = stla_pkg::SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int RANDOM_PER_PHASE = 166;
   localparam int PHASES           = 5;
   localparam int POOL             = 10;

   typedef struct packed {
      logic [stla_pkg::COUNT_OUT_W-1:0] expired_count;
      logic [stla_pkg::ID_W-1:0]        evicted_node;
      logic                             hit;
      logic [stla_pkg::SLOT_OUT_W-1:0]  slot;
   } session_rsp_type;

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   class session_scoreboard;
      logic [stla_pkg::ID_W-1:0]   node_tab [SLOTS];
      logic [stla_pkg::TIME_W-1:0] active_tab [SLOTS];
      logic [stla_pkg::TIME_W-1:0] idle_timeout;
      session_rsp_type             expected_q [$];
      int mismatches;
      int accesses;
      int expires;
      int hits;
      int evictions;
      int freed;

      function new();
         foreach (node_tab[i]) begin
            node_tab[i]   = '0;
            active_tab[i] = '0;
         end
         idle_timeout = stla_pkg::IDLE_TIMEOUT_RESET;
         mismatches   = 0;
         accesses     = 0;
         expires      = 0;
         hits         = 0;
         evictions    = 0;
         freed        = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      function void note_request(logic op, logic [stla_pkg::ID_W-1:0] node,
                                 logic [stla_pkg::TIME_W-1:0] stamp);
         session_rsp_type             r;
         int                          s;
         int                          n;
         logic [stla_pkg::TIME_W-1:0] idle;
         r = '0;
         s = -1;
         n = 0;
         if (op == stla_pkg::OP_ACCESS) begin
            accesses++;
            for (int i = 0; i < SLOTS; i++)
               if (s < 0 && node_tab[i] == node)
                  s = i;
            if (s >= 0) begin
               r.hit = 1'b1;
               hits++;
            end else begin
               s = 0;
               for (int i = 1; i < SLOTS; i++)
                  if (active_tab[i] < active_tab[s])
                     s = i;
               r.evicted_node = node_tab[s];
               if (node_tab[s] != '0)
                  evictions++;
               node_tab[s] = node;
            end
            active_tab[s] = stamp;
            r.slot = s[stla_pkg::SLOT_OUT_W-1:0];
         end else begin
            expires++;
            for (int i = 0; i < SLOTS; i++) begin
               idle = stamp - active_tab[i];
               if (node_tab[i] != '0 && idle > idle_timeout) begin
                  node_tab[i] = '0;
                  n++;
               end
            end
            freed += n;
            r.expired_count = n[stla_pkg::COUNT_OUT_W-1:0];
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [stla_pkg::RSP_DATA_W-1:0] data);
         session_rsp_type got;
         session_rsp_type want;
         got = data;
         if (expected_q.size() == 0) begin
            flag($sformatf("result %h with nothing expected", data));
            return;
         end
         want = expected_q.pop_front();
         if (got.slot !== want.slot)
            flag($sformatf("slot exp %0d got %0d", want.slot, got.slot));
         if (got.hit !== want.hit)
            flag($sformatf("hit exp %0b got %0b", want.hit, got.hit));
         if (got.evicted_node !== want.evicted_node)
            flag($sformatf("evicted_node exp %h got %h", want.evicted_node, got.evicted_node));
         if (got.expired_count !== want.expired_count)
            flag($sformatf("expired_count exp %0d got %0d", want.expired_count,
                           got.expired_count));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [stla_pkg::REQ_DATA_W-1:0] req_tdata;   // node_id, now
   logic                            req_tuser;   // op
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [stla_pkg::RSP_DATA_W-1:0] rsp_tdata;   // slot, hit, evicted_node, expired_count
   logic                            csr_we;
   logic [stla_pkg::TIME_W-1:0]     csr_wdata;

   session_scoreboard           sb;
   int                          cycles     = 0;
   int                          burst_left = 0;
   int                          stall_left = 0;
   rx_mode_type                 stall_mode = RX_OPEN;
   logic [stla_pkg::TIME_W-1:0] wall_clock;
   logic [stla_pkg::ID_W-1:0]   pool [POOL];
   logic [stla_pkg::TIME_W-1:0] timeouts [PHASES];

   session_table_lru_aging_core #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= rx_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 150);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         RX_OPEN:  rsp_tready <= 1'b1;
         RX_LIGHT: rsp_tready <= ($urandom_range(0, 9) < 7);
         RX_HEAVY: rsp_tready <= ($urandom_range(0, 9) < 2);
         default:  rsp_tready <= (stall_left % 6 == 0);
      endcase
   end

   task automatic send_item(logic op, logic [stla_pkg::ID_W-1:0] node,
                            logic [stla_pkg::TIME_W-1:0] stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {stamp, node};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, node, stamp);
      burst_left--;
      @(negedge clock);
   endtask

   // hold off the sender until every outstanding result is back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_timeout(logic [stla_pkg::TIME_W-1:0] value);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.idle_timeout = value;
      @(negedge clock);
   endtask

   task automatic random_item();
      logic                      op;
      logic [stla_pkg::ID_W-1:0] node;
      int                        pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         wall_clock = $urandom;
      else if (pick < 6)
         wall_clock = 32'hFFFF_FF00 + $urandom_range(0, 200);
      else
         wall_clock = wall_clock + $urandom_range(0, 40);
      op = ($urandom_range(0, 99) < 15) ? stla_pkg::OP_EXPIRE : stla_pkg::OP_ACCESS;
      if ($urandom_range(0, 99) < 65)
         node = pool[$urandom_range(0, POOL - 1)];
      else
         node = $urandom;
      send_item(op, node, wall_clock);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = stla_pkg::OP_ACCESS;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      wall_clock = '0;
      sb = new();
      timeouts[0] = '0;
      timeouts[1] = 32'hFFFF_FFFF;
      timeouts[2] = $urandom_range(20, 300);
      timeouts[3] = $urandom;
      timeouts[4] = stla_pkg::IDLE_TIMEOUT_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty-slot id zero, fill, hits, LRU eviction, expiry and time wrap
      send_item(stla_pkg::OP_ACCESS, 32'h0000_0000, 32'd0);
      send_item(stla_pkg::OP_ACCESS, 32'hFFFF_FFFF, 32'd5);
      send_item(stla_pkg::OP_ACCESS, 32'd1, 32'd10);
      send_item(stla_pkg::OP_ACCESS, 32'd2, 32'd20);
      send_item(stla_pkg::OP_ACCESS, 32'd3, 32'd30);
      send_item(stla_pkg::OP_ACCESS, 32'd4, 32'd40);
      send_item(stla_pkg::OP_ACCESS, 32'd5, 32'd50);
      send_item(stla_pkg::OP_ACCESS, 32'd6, 32'd60);
      send_item(stla_pkg::OP_ACCESS, 32'h0000_0000, 32'd70);
      send_item(stla_pkg::OP_ACCESS, 32'd2, 32'd80);
      send_item(stla_pkg::OP_ACCESS, 32'd9, 32'd90);
      send_item(stla_pkg::OP_EXPIRE, 32'hFFFF_FFFF, 32'd600);
      send_item(stla_pkg::OP_EXPIRE, 32'h0000_0000, 32'd700);
      send_item(stla_pkg::OP_ACCESS, 32'h0000_0000, 32'd710);
      send_item(stla_pkg::OP_ACCESS, 32'h0000_0000, 32'd720);
      send_item(stla_pkg::OP_ACCESS, 32'd7, 32'hFFFF_FFF0);
      send_item(stla_pkg::OP_ACCESS, 32'h8000_0000, 32'h8000_0000);
      send_item(stla_pkg::OP_EXPIRE, 32'd0, 32'h0000_0100);
      send_item(stla_pkg::OP_ACCESS, 32'd12, 32'h0000_0000);
      send_item(stla_pkg::OP_EXPIRE, 32'd0, 32'hFFFF_FFFF);
      send_item(stla_pkg::OP_ACCESS, 32'h5555_AAAA, 32'hFFFF_FFFF);

      for (int p = 0; p < PHASES; p++) begin
         write_timeout(timeouts[p]);
         pool[0] = '0;
         pool[1] = 32'hFFFF_FFFF;
         for (int k = 2; k < POOL; k++)
            pool[k] = $urandom;
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            random_item();
            if (k == 80)
               wait_drain();
         end
      end

      wait_drain();
      repeat (4 * (SLOTS + 3)) @(posedge clock);

      $display("covered %0d accesses (%0d hits, %0d live evictions), %0d expires freeing %0d",
               sb.accesses, sb.hits, sb.evictions, sb.expires, sb.freed);
      $display("idle timeouts 600, 0, all ones, %0d, %0d; %0d field mismatches",
               timeouts[2], timeouts[3], sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
